@@ rtl/core/svpm_pkg.sv @@
`timescale 1ns / 1ps
package svpm_pkg;

  localparam int unsigned PrefixBlocks = 2;
  localparam int unsigned TailBytes = 9;
  localparam logic [63:0] MsgBits = 64'((PrefixBlocks * 64 + TailBytes + 4) * 8);
  localparam int unsigned Rounds = 80;

  localparam logic [2:0] REG_MID_AB = 3'd0;
  localparam logic [2:0] REG_MID_CD = 3'd1;
  localparam logic [2:0] REG_MID_E = 3'd2;
  localparam logic [2:0] REG_TAIL_HI = 3'd3;
  localparam logic [2:0] REG_TAIL_LO = 3'd4;
  localparam logic [2:0] REG_TGT_HI = 3'd5;
  localparam logic [2:0] REG_TGT_LO = 3'd6;
  localparam logic [2:0] REG_PCHARS = 3'd7;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] sched_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } hstate_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic hstate_t sha_round(input hstate_t s, input word_t w,
                                        input int unsigned i);
    word_t f;
    word_t k;
    hstate_t r;
    if (i < 20) begin
      f = (s.b & s.c) | (~s.b & s.d);
      k = 32'h5A827999;
    end else if (i < 40) begin
      f = s.b ^ s.c ^ s.d;
      k = 32'h6ED9EBA1;
    end else if (i < 60) begin
      f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
      k = 32'h8F1BBCDC;
    end else begin
      f = s.b ^ s.c ^ s.d;
      k = 32'hCA62C1D6;
    end
    r.a = rotl(s.a, 5) + f + s.e + k + w;
    r.b = s.a;
    r.c = rotl(s.b, 30);
    r.d = s.c;
    r.e = s.d;
    sha_round = r;
  endfunction

endpackage

@@ rtl/core/sha1_exponent_prefix_matcher_top.sv @@
`timescale 1ns / 1ps
// Fully unrolled SHA-1 pipeline: one exponent is taken every cycle (busy is
// always low) and its result strobes on out_valid after passing through a
// register for the final block, one register per round for the 80
// rounds, and one for the midstate add and prefix compare. The receiver
// cannot stall. Configuration must only be written with no item in flight.
module sha1_exponent_prefix_matcher_top
  import svpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_exponent,
  output logic        out_valid,
  output logic        out_match,
  output logic [31:0] out_exponent_echo,
  output logic [63:0] out_digest_head,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] mid_ab_r, mid_cd_r, tail_hi_r, tgt_hi_r;
  logic [31:0] mid_e_r;
  logic [7:0]  tail_lo_r;
  logic [15:0] tgt_lo_r;
  logic [4:0]  pchars_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_ab_r <= '0; mid_cd_r <= '0; mid_e_r <= '0; tail_hi_r <= '0;
      tail_lo_r <= '0; tgt_hi_r <= '0; tgt_lo_r <= '0; pchars_r <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MID_AB:  mid_ab_r <= cfg_data;
        REG_MID_CD:  mid_cd_r <= cfg_data;
        REG_MID_E:   mid_e_r <= cfg_data[31:0];
        REG_TAIL_HI: tail_hi_r <= cfg_data;
        REG_TAIL_LO: tail_lo_r <= cfg_data[7:0];
        REG_TGT_HI:  tgt_hi_r <= cfg_data;
        REG_TGT_LO:  tgt_lo_r <= cfg_data[15:0];
        REG_PCHARS:  pchars_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Final block: tail bytes, exponent, 0x80 marker, zeros, bit length.
  logic [511:0] blk;
  always_comb begin
    logic [71:0] tail9;
    logic [511:0] raw;
    tail9 = {tail_hi_r, tail_lo_r};
    raw = '0;
    raw[511 -: 72] = tail9;
    raw[439 -: 32] = in_exponent;
    raw[407 -: 8]  = 8'h80;
    blk = raw << (8 * (9 - TailBytes));
    blk[63:0] = MsgBits;
  end

  logic    v_r [Rounds+1];
  hstate_t s_r [Rounds+1];
  sched_t  w_r [Rounds+1];
  word_t   x_r [Rounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= start;
    s_r[0] <= {mid_ab_r, mid_cd_r, mid_e_r};
    w_r[0] <= blk;
    x_r[0] <= in_exponent;
  end

  // w_r holds a 16-word window; word 15 is the word used this round.
  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    word_t wn;
    assign wn = rotl(w_r[g][2] ^ w_r[g][7] ^ w_r[g][13] ^ w_r[g][15], 1);
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g+1] <= 1'b0;
      else v_r[g+1] <= v_r[g];
      s_r[g+1] <= sha_round(s_r[g], w_r[g][15], g);
      w_r[g+1] <= {w_r[g][14:0], wn};
      x_r[g+1] <= x_r[g];
    end
  end

  word_t h0, h1, h2;
  logic [63:0] dhi, mhi;
  logic [15:0] dlo, mlo;
  logic [6:0] nbits;
  logic [4:0] nch;
  assign h0 = s_r[Rounds].a + mid_ab_r[63:32];
  assign h1 = s_r[Rounds].b + mid_ab_r[31:0];
  assign h2 = s_r[Rounds].c + mid_cd_r[63:32];
  assign dhi = {h0, h1};
  assign dlo = h2[31:16];
  assign nch = (pchars_r > 5'd16) ? 5'd16 : pchars_r;
  assign nbits = 7'(nch * 5);
  always_comb begin
    if (nbits == 7'd0) begin
      mhi = '0; mlo = '0;
    end else if (nbits <= 7'd64) begin
      mhi = ~64'd0 << (7'd64 - nbits); mlo = '0;
    end else begin
      mhi = ~64'd0; mlo = 16'hFFFF << (7'd80 - nbits);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= v_r[Rounds];
    out_match <= (((dhi ^ tgt_hi_r) & mhi) == '0) && (((dlo ^ tgt_lo_r) & mlo) == '0);
    out_exponent_echo <= x_r[Rounds];
    out_digest_head <= dhi;
  end

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> ##81 out_valid) else $error("result lost");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[Rounds] |=> out_exponent_echo == $past(x_r[Rounds])) else $error("echo");
`endif

endmodule
